// ----- src/cmlp_pkg.sv -----
// Shared types and constants for the color matrix unit with luma preservation.
// No dependencies; every other file of the block imports this package.
package cmlp_pkg;

    // Fixed-point format of pixels and matrix coefficients.
    localparam int FRAC_BITS    = 12;
    localparam int HALF_LSB     = 1 << (FRAC_BITS - 1);

    // Blend and keep weights are unsigned Q1.12, 4096 meaning full strength.
    localparam int WEIGHT_SHIFT = 12;
    localparam int WEIGHT_ONE   = 1 << WEIGHT_SHIFT;
    localparam int WEIGHT_HALF  = 1 << (WEIGHT_SHIFT - 1);

    // BT.709 luma weights in Q0.12.
    localparam int LUMA_WR = 871;
    localparam int LUMA_WG = 2929;
    localparam int LUMA_WB = 296;

    // Output saturation limits, signed Q5.12.
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    // Ratio cap of 16.0 and the quotient width below the cap.
    localparam int QUOT_BITS = 16;
    localparam int RATIO_CAP = 16 << FRAC_BITS;

    // Number of pipeline stages in each part.
    localparam int MAT_STAGES   = 3;
    localparam int DIV_STAGES   = QUOT_BITS + 1;
    localparam int SCALE_STAGES = 6;
    localparam int ALL_STAGES   = MAT_STAGES + DIV_STAGES + SCALE_STAGES;

    // Configuration register indexes.
    localparam logic [2:0] REG_ROW_RED   = 3'd0;
    localparam logic [2:0] REG_ROW_GREEN = 3'd1;
    localparam logic [2:0] REG_ROW_BLUE  = 3'd2;
    localparam logic [2:0] REG_MIX       = 3'd3;
    localparam logic [2:0] REG_KEEP      = 3'd4;

    // Register reset values.
    localparam logic [47:0] ROW_RED_RST   = 48'h0000_0000_1000;
    localparam logic [47:0] ROW_GREEN_RST = 48'h0000_1000_0000;
    localparam logic [47:0] ROW_BLUE_RST  = 48'h1000_0000_0000;
    localparam logic [12:0] MIX_RST       = 13'd4096;
    localparam logic [12:0] KEEP_RST      = 13'd0;

    typedef logic [15:0] pix_t;

    typedef struct packed {
        pix_t b;
        pix_t g;
        pix_t r;
    } rgb_t;

    // Rounded matrix products, signed with FRAC_BITS fraction bits.
    typedef logic signed [23:0] prod_t;

    typedef struct packed {
        prod_t b;
        prod_t g;
        prod_t r;
    } prod3_t;

    typedef logic signed [17:0] out_t;

endpackage

// ----- src/cmlp_matrix.sv -----
// Matrix stages: nine coefficient products, rounded row sums and both luma sums.
// Depends on cmlp_pkg.
module cmlp_matrix import cmlp_pkg::*; (
    input  logic                     aclk,
    input  logic [MAT_STAGES-1:0]    en,
    input  rgb_t                     pix_in,
    input  logic [47:0]              row_red,
    input  logic [47:0]              row_green,
    input  logic [47:0]              row_blue,
    output rgb_t                     pix_out,
    output prod3_t                   prod_out,
    output logic [27:0]              luma_in_out,
    output logic signed [34:0]       luma_new_out
);

    logic [47:0] rows [3];
    pix_t        px   [3];

    logic signed [32:0] mul_reg  [3][3];
    logic signed [32:0] mul_next [3][3];
    logic [27:0]        lin_reg, lin_next, lin2_reg, lin3_reg;
    rgb_t               pix1_reg, pix2_reg, pix3_reg;
    prod_t              rm_reg   [3];
    prod_t              rm_next  [3];
    prod3_t             prod3_reg;
    logic signed [34:0] lnew_reg, lnew_next;

    assign rows[0] = row_red;
    assign rows[1] = row_green;
    assign rows[2] = row_blue;
    assign px[0]   = pix_in.r;
    assign px[1]   = pix_in.g;
    assign px[2]   = pix_in.b;

    // First stage: coefficient products and input luma.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                mul_next[i][k] = 33'($signed(rows[i][16*k +: 16]))
                               * 33'($signed({1'b0, px[k]}));
            end
        end
        lin_next = 28'(LUMA_WR) * 28'(pix_in.r) + 28'(LUMA_WG) * 28'(pix_in.g)
                 + 28'(LUMA_WB) * 28'(pix_in.b);
    end

    // Second stage: row sums rounded half up to FRAC_BITS.
    always_comb begin
        logic signed [34:0] sum;
        logic signed [34:0] rnd;
        for (int i = 0; i < 3; i++) begin
            sum = 35'(mul_reg[i][0]) + 35'(mul_reg[i][1]) + 35'(mul_reg[i][2]);
            rnd = (sum + 35'(HALF_LSB)) >>> FRAC_BITS;
            rm_next[i] = rnd[23:0];
        end
    end

    // Third stage: luma of the matrix result.
    always_comb begin
        logic signed [35:0] acc;
        acc = 36'(LUMA_WR) * 36'(rm_reg[0]) + 36'(LUMA_WG) * 36'(rm_reg[1])
            + 36'(LUMA_WB) * 36'(rm_reg[2]);
        lnew_next = acc[34:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mul_reg  <= mul_next;
            lin_reg  <= lin_next;
            pix1_reg <= pix_in;
        end
        if (en[1]) begin
            rm_reg   <= rm_next;
            lin2_reg <= lin_reg;
            pix2_reg <= pix1_reg;
        end
        if (en[2]) begin
            prod3_reg <= '{b: rm_reg[2], g: rm_reg[1], r: rm_reg[0]};
            lnew_reg  <= lnew_next;
            lin3_reg  <= lin2_reg;
            pix3_reg  <= pix2_reg;
        end
    end

    assign pix_out      = pix3_reg;
    assign prod_out     = prod3_reg;
    assign luma_in_out  = lin3_reg;
    assign luma_new_out = lnew_reg;

endmodule

// ----- src/cmlp_divider.sv -----
// Pipelined restoring divider for the luma ratio, one quotient bit per stage.
// Depends on cmlp_pkg.
module cmlp_divider import cmlp_pkg::*; (
    input  logic                     aclk,
    input  logic [DIV_STAGES-1:0]    en,
    input  rgb_t                     pix_in,
    input  prod3_t                   prod_in,
    input  logic [27:0]              luma_in,
    input  logic signed [34:0]       luma_new,
    output rgb_t                     pix_out,
    output prod3_t                   prod_out,
    output logic [16:0]              ratio
);

    logic [39:0]          rem_reg  [DIV_STAGES];
    logic [33:0]          den_reg  [DIV_STAGES];
    logic [QUOT_BITS-1:0] quot_reg [DIV_STAGES];
    logic                 byp_reg  [DIV_STAGES];
    logic                 cap_reg  [DIV_STAGES];
    rgb_t                 pix_reg  [DIV_STAGES];
    prod3_t               prod_reg [DIV_STAGES];

    logic byp_next, cap_next;

    // Entry stage: ratio bypass when product luma is not positive, cap at 16.0.
    always_comb begin
        byp_next = (luma_new <= 35'sd0);
        cap_next = !byp_next && (40'(luma_in) >= (40'(luma_new[33:0]) << 4));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= {luma_in, 12'd0};
            den_reg[0]  <= luma_new[33:0];
            quot_reg[0] <= '0;
            byp_reg[0]  <= byp_next;
            cap_reg[0]  <= cap_next;
            pix_reg[0]  <= pix_in;
            prod_reg[0] <= prod_in;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
        localparam int BIT = QUOT_BITS - j;
        logic [39:0]          rem_next;
        logic [QUOT_BITS-1:0] quot_next;

        always_comb begin
            logic [49:0] trial;
            trial     = 50'(den_reg[j-1]) << BIT;
            rem_next  = rem_reg[j-1];
            quot_next = quot_reg[j-1];
            if (50'(rem_reg[j-1]) >= trial) begin
                rem_next       = rem_reg[j-1] - trial[39:0];
                quot_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_reg[j-1];
                quot_reg[j] <= quot_next;
                byp_reg[j]  <= byp_reg[j-1];
                cap_reg[j]  <= cap_reg[j-1];
                pix_reg[j]  <= pix_reg[j-1];
                prod_reg[j] <= prod_reg[j-1];
            end
        end
    end

    // Final ratio selection.
    always_comb begin
        if (byp_reg[DIV_STAGES-1]) begin
            ratio = 17'(1 << FRAC_BITS);
        end else if (cap_reg[DIV_STAGES-1]) begin
            ratio = 17'(RATIO_CAP);
        end else begin
            ratio = {1'b0, quot_reg[DIV_STAGES-1]};
        end
    end

    assign pix_out  = pix_reg[DIV_STAGES-1];
    assign prod_out = prod_reg[DIV_STAGES-1];

endmodule

// ----- src/cmlp_scale.sv -----
// Scale stages: luma correction factor, product scaling, blend and saturation.
// Depends on cmlp_pkg.
module cmlp_scale import cmlp_pkg::*; (
    input  logic                      aclk,
    input  logic [SCALE_STAGES-1:0]   en,
    input  rgb_t                      pix_in,
    input  prod3_t                    prod_in,
    input  logic [16:0]               ratio,
    input  logic [12:0]               keep_weight,
    input  logic [12:0]               mix_weight,
    output out_t                      red_out,
    output out_t                      green_out,
    output out_t                      blue_out
);

    rgb_t               pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;
    prod3_t             prod1_reg, prod2_reg;
    logic signed [30:0] kp_reg, kp_next;
    logic signed [18:0] corr_reg, corr_next;
    logic signed [42:0] pr_reg   [3];
    logic signed [42:0] pr_next  [3];
    logic signed [27:0] diff_reg [3];
    logic signed [27:0] diff_next[3];
    logic signed [41:0] dm_reg   [3];
    logic signed [41:0] dm_next  [3];
    out_t               out_reg  [3];
    out_t               out_next [3];
    prod_t              pv [3];
    pix_t               p3 [3];
    pix_t               p5 [3];

    assign pv[0] = prod2_reg.r;
    assign pv[1] = prod2_reg.g;
    assign pv[2] = prod2_reg.b;
    assign p3[0] = pix3_reg.r;
    assign p3[1] = pix3_reg.g;
    assign p3[2] = pix3_reg.b;
    assign p5[0] = pix5_reg.r;
    assign p5[1] = pix5_reg.g;
    assign p5[2] = pix5_reg.b;

    // Ratio minus one, weighted by the keep strength.
    always_comb begin
        logic signed [17:0] rd;
        rd      = $signed({1'b0, ratio}) - 18'(1 << FRAC_BITS);
        kp_next = 31'(rd) * 31'($signed({1'b0, keep_weight}));
    end

    // Correction factor with FRAC_BITS fraction bits.
    always_comb begin
        logic signed [30:0] t;
        t         = (kp_reg + 31'(WEIGHT_HALF)) >>> WEIGHT_SHIFT;
        corr_next = 19'(t) + 19'(1 << FRAC_BITS);
    end

    // Scaled products, the difference to the input, then its mix weighting.
    always_comb begin
        logic signed [42:0] t;
        logic signed [43:0] d;
        for (int i = 0; i < 3; i++) begin
            pr_next[i]   = 43'(pv[i]) * 43'(corr_reg);
            t            = (pr_reg[i] + 43'(HALF_LSB)) >>> FRAC_BITS;
            d            = 44'(t) - 44'($signed({1'b0, p3[i]}));
            diff_next[i] = d[27:0];
            dm_next[i]   = 42'(diff_reg[i]) * 42'($signed({1'b0, mix_weight}));
        end
    end

    // Blend back onto the input and saturate.
    always_comb begin
        logic signed [41:0] t;
        logic signed [42:0] v;
        for (int i = 0; i < 3; i++) begin
            t = (dm_reg[i] + 42'(WEIGHT_HALF)) >>> WEIGHT_SHIFT;
            v = 43'(t) + 43'($signed({1'b0, p5[i]}));
            if (v > 43'(OUT_MAX)) begin
                out_next[i] = 18'(OUT_MAX);
            end else if (v < 43'(OUT_MIN)) begin
                out_next[i] = 18'(OUT_MIN);
            end else begin
                out_next[i] = v[17:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            kp_reg    <= kp_next;
            pix1_reg  <= pix_in;
            prod1_reg <= prod_in;
        end
        if (en[1]) begin
            corr_reg  <= corr_next;
            pix2_reg  <= pix1_reg;
            prod2_reg <= prod1_reg;
        end
        if (en[2]) begin
            pr_reg   <= pr_next;
            pix3_reg <= pix2_reg;
        end
        if (en[3]) begin
            diff_reg <= diff_next;
            pix4_reg <= pix3_reg;
        end
        if (en[4]) begin
            dm_reg   <= dm_next;
            pix5_reg <= pix4_reg;
        end
        if (en[5]) begin
            out_reg <= out_next;
        end
    end

    assign red_out   = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out  = out_reg[2];

endmodule

// ----- src/color_matrix_luma_preserve_unit.sv -----
// Color correction matrix with luma preservation: pixel stream in, corrected stream out.
// Depends on cmlp_pkg, cmlp_matrix, cmlp_divider and cmlp_scale.
//
// Usage:
//   Pixels enter on the s_ stream (red, green, blue, unsigned Q4.12) and leave on
//   the m_ stream (signed Q5.12, saturated), one result per pixel, in order.
//   The block accepts one pixel per clock cycle while s_tready is high, which
//   drops only when every stage is full and the receiver stalls. A pixel passes
//   the 3 matrix stages, the 17 bit-per-stage divider stages and the 6 scaling stages.
//   Every stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles are squeezed out and a stalled
//   receiver only holds the stages that are full; nothing is dropped or repeated.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the user must
//   write it only while no pixel is in flight; the block does not enforce this.
//   Weights above 4096 act as 4096; writes to indexes past the register list are ignored.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   identity matrix, full mix and no luma preservation.
module color_matrix_luma_preserve_unit import cmlp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red_out[17:0], green_out[35:18], blue_out[53:36], zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    logic [47:0]           row_red_reg, row_green_reg, row_blue_reg;
    logic [12:0]           mix_reg, keep_reg;
    logic [12:0]           weight_next;
    logic [ALL_STAGES-1:0] valid_reg, valid_next;
    logic [ALL_STAGES-1:0] en;

    rgb_t               mat_pix, div_pix;
    prod3_t             mat_prod, div_prod;
    logic [27:0]        luma_in;
    logic signed [34:0] luma_new;
    logic [16:0]        ratio;
    out_t               red_o, green_o, blue_o;

    // Weights above full strength are stored as full strength.
    assign weight_next = (cfg_wdata[12:0] > 13'(WEIGHT_ONE)) ? 13'(WEIGHT_ONE)
                                                             : cfg_wdata[12:0];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_red_reg   <= ROW_RED_RST;
            row_green_reg <= ROW_GREEN_RST;
            row_blue_reg  <= ROW_BLUE_RST;
            mix_reg       <= MIX_RST;
            keep_reg      <= KEEP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROW_RED:   row_red_reg   <= cfg_wdata;
                REG_ROW_GREEN: row_green_reg <= cfg_wdata;
                REG_ROW_BLUE:  row_blue_reg  <= cfg_wdata;
                REG_MIX:       mix_reg       <= weight_next;
                REG_KEEP:      keep_reg      <= weight_next;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor loads.
    always_comb begin
        en[ALL_STAGES-1] = !valid_reg[ALL_STAGES-1] || m_tready;
        for (int k = ALL_STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb begin
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < ALL_STAGES; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    cmlp_matrix u_matrix (
        .aclk         (aclk),
        .en           (en[MAT_STAGES-1:0]),
        .pix_in       (s_tdata),
        .row_red      (row_red_reg),
        .row_green    (row_green_reg),
        .row_blue     (row_blue_reg),
        .pix_out      (mat_pix),
        .prod_out     (mat_prod),
        .luma_in_out  (luma_in),
        .luma_new_out (luma_new)
    );

    cmlp_divider u_divider (
        .aclk     (aclk),
        .en       (en[MAT_STAGES +: DIV_STAGES]),
        .pix_in   (mat_pix),
        .prod_in  (mat_prod),
        .luma_in  (luma_in),
        .luma_new (luma_new),
        .pix_out  (div_pix),
        .prod_out (div_prod),
        .ratio    (ratio)
    );

    cmlp_scale u_scale (
        .aclk        (aclk),
        .en          (en[MAT_STAGES+DIV_STAGES +: SCALE_STAGES]),
        .pix_in      (div_pix),
        .prod_in     (div_prod),
        .ratio       (ratio),
        .keep_weight (keep_reg),
        .mix_weight  (mix_reg),
        .red_out     (red_o),
        .green_out   (green_o),
        .blue_out    (blue_o)
    );

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[ALL_STAGES-1];
    assign m_tdata  = {2'b00, blue_o, green_o, red_o};

endmodule

// ----- tb/color_matrix_luma_preserve_unit_tb.sv -----
// Testbench for color_matrix_luma_preserve_unit: directed table plus random pixels,
// checked against a built-in predictor of the matrix, luma and blend arithmetic.
// Depends on cmlp_pkg and the RTL of the unit.
module color_matrix_luma_preserve_unit_tb;
    import cmlp_pkg::*;

    localparam int LATENCY  = ALL_STAGES + 4;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1450;
    localparam int N_TABLE  = 16;

    // Index past the end of the register list.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Stall patterns of the sender and the receiver.
    typedef enum int {MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH} idle_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // red_in[15:0], green_in[31:16], blue_in[47:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // red_out[17:0], green_out[35:18], blue_out[53:36], zero
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;

    // Predictor copy of the configuration.
    logic [47:0] row_red_q, row_green_q, row_blue_q;
    logic [12:0] mix_q, keep_q;

    logic [53:0] expected_pixels[$];
    int          mismatch_count;
    int          quiet_cycles;
    idle_mode_t  idle_mode;
    bit          hold_off;

    // Directed stimulus: pixel, and a known result where one is obvious.
    typedef struct {
        logic [47:0] pixel;
        bit          known;
        logic [53:0] result;
    } table_row_t;
    table_row_t stim_table[N_TABLE];

    color_matrix_luma_preserve_unit uut (.*);

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint coef_of(logic [47:0] row, int k);
        return longint'($signed(row[16*k +: 16]));
    endfunction

    function automatic longint row_sum(logic [47:0] row, longint r, longint g, longint b);
        return round_shift(coef_of(row, 0) * r + coef_of(row, 1) * g + coef_of(row, 2) * b,
                           FRAC_BITS);
    endfunction

    function automatic logic [17:0] blend_saturate(longint in_v, longint prod, longint mix);
        longint v;
        v = in_v + round_shift((prod - in_v) * mix, WEIGHT_SHIFT);
        if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
        if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
        return v[17:0];
    endfunction

    // Expected corrected pixel for the present configuration.
    function automatic logic [53:0] correct_pixel(logic [47:0] px);
        longint r, g, b, rm, gm, bm, keep, mix, lin, lnew, ratio, corr, one;
        one  = longint'(1) << FRAC_BITS;
        r    = longint'(px[15:0]);
        g    = longint'(px[31:16]);
        b    = longint'(px[47:32]);
        rm   = row_sum(row_red_q, r, g, b);
        gm   = row_sum(row_green_q, r, g, b);
        bm   = row_sum(row_blue_q, r, g, b);
        keep = longint'((keep_q > 13'(WEIGHT_ONE)) ? 13'(WEIGHT_ONE) : keep_q);
        mix  = longint'((mix_q > 13'(WEIGHT_ONE)) ? 13'(WEIGHT_ONE) : mix_q);
        if (keep != 0) begin
            lin   = LUMA_WR * r + LUMA_WG * g + LUMA_WB * b;
            lnew  = LUMA_WR * rm + LUMA_WG * gm + LUMA_WB * bm;
            ratio = one;
            if (lnew > 0) begin
                ratio = (lin * one) / lnew;
                if (ratio > longint'(RATIO_CAP)) ratio = longint'(RATIO_CAP);
            end
            corr = one + round_shift((ratio - one) * keep, WEIGHT_SHIFT);
            rm   = round_shift(rm * corr, FRAC_BITS);
            gm   = round_shift(gm * corr, FRAC_BITS);
            bm   = round_shift(bm * corr, FRAC_BITS);
        end
        return {blend_saturate(b, bm, mix), blend_saturate(g, gm, mix),
                blend_saturate(r, rm, mix)};
    endfunction

    task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
        $display("Mismatch on %s: got %0d, expected %0d", what, $signed(got), $signed(want));
        mismatch_count++;
    endtask

    // Result checker and receiver stalls.
    always @(posedge aclk) begin
        logic [53:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[17:0], 18'h0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[17:0] !== want[17:0])
                        report_mismatch("red", m_tdata[17:0], want[17:0]);
                    if (m_tdata[35:18] !== want[35:18])
                        report_mismatch("green", m_tdata[35:18], want[35:18]);
                    if (m_tdata[53:36] !== want[53:36])
                        report_mismatch("blue", m_tdata[53:36], want[53:36]);
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (idle_mode == MODE_RECV)
                m_tready <= ($urandom_range(99) >= 68);
            else if (idle_mode == MODE_BOTH)
                m_tready <= ($urandom_range(99) >= 15);
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    task automatic long_hold_off();
        hold_off = 1'b1;
        repeat (200) @(posedge aclk);
        hold_off = 1'b0;
    endtask

    task automatic write_register(logic [2:0] idx, logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROW_RED:   row_red_q   = val;
            REG_ROW_GREEN: row_green_q = val;
            REG_ROW_BLUE:  row_blue_q  = val;
            REG_MIX:       mix_q       = val[12:0];
            REG_KEEP:      keep_q      = val[12:0];
            default: ;
        endcase
    endtask

    // Send one pixel; expectation is queued at the accepting edge.
    task automatic send_pixel(logic [47:0] px, bit known, logic [53:0] result);
        if (idle_mode == MODE_SEND || idle_mode == MODE_BOTH) begin
            while ($urandom_range(99) < (idle_mode == MODE_SEND ? 68 : 15)) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(known ? result : correct_pixel(px));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [47:0] random_row();
        logic [47:0] row;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(3))
                0: row[16*k +: 16] = 16'($urandom());
                1: row[16*k +: 16] = 16'(int'($urandom_range(8192)) - 4096);
                2: row[16*k +: 16] = 16'(int'($urandom_range(1500)) + 3400);
                default: row[16*k +: 16] = 16'(int'($urandom_range(2000)) - 1000);
            endcase
        end
        return row;
    endfunction

    function automatic logic [47:0] random_pixel();
        logic [47:0] px;
        for (int k = 0; k < 3; k++)
            px[16*k +: 16] = ($urandom_range(3) == 0) ? 16'($urandom()) :
                             16'($urandom_range(8192));
        return px;
    endfunction

    initial begin
        logic [47:0] px;
        mismatch_count = 0;
        idle_mode      = MODE_NONE;
        hold_off       = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        row_red_q      = ROW_RED_RST;
        row_green_q    = ROW_GREEN_RST;
        row_blue_q     = ROW_BLUE_RST;
        mix_q          = MIX_RST;
        keep_q         = KEEP_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset the identity matrix passes pixels through unchanged.
        stim_table[0] = '{48'h0, 1'b1, 54'h0};
        stim_table[1] = '{48'hFFFF_FFFF_FFFF, 1'b1, {18'hFFFF, 18'hFFFF, 18'hFFFF}};
        stim_table[2] = '{48'h0001_8000_1000, 1'b1, {18'h1, 18'h8000, 18'h1000}};
        stim_table[3] = '{48'hAAAA_5555_0F0F, 1'b1, {18'hAAAA, 18'h5555, 18'h0F0F}};
        for (int i = 4; i < N_TABLE; i++)
            stim_table[i] = '{random_pixel(), 1'b0, 54'h0};
        stim_table[4].pixel = 48'hFFFF_0000_0000;
        stim_table[5].pixel = 48'h0000_FFFF_0000;
        stim_table[6].pixel = 48'h0000_0000_FFFF;
        for (int i = 0; i < N_TABLE; i++)
            send_pixel(stim_table[i].pixel, stim_table[i].known, stim_table[i].result);
        wait_drained();

        // Extreme matrices: most negative, most positive, mixed; keep and mix above range, acting as full.
        write_register(REG_ROW_RED, 48'h8000_8000_8000);
        write_register(REG_ROW_GREEN, 48'h7FFF_7FFF_7FFF);
        write_register(REG_ROW_BLUE, 48'h0000_8000_7FFF);
        write_register(REG_KEEP, 48'h1FFF);
        write_register(REG_MIX, 48'h1FFF);
        // Illegal index must be ignored.
        write_register(REG_UNUSED, 48'h1234_5678_9ABC);
        for (int i = 0; i < N_TABLE; i++)
            send_pixel(stim_table[i].pixel, 1'b0, '0);
        wait_drained();
        write_register(REG_MIX, 48'd0);
        write_register(REG_KEEP, 48'd4096);
        for (int i = 0; i < 6; i++)
            send_pixel(stim_table[i].pixel, 1'b0, '0);
        wait_drained();

        // Random phases over the stall patterns, new configuration each phase.
        for (int phase = 0; phase < 8; phase++) begin
            idle_mode = idle_mode_t'(phase % 4);
            write_register(REG_ROW_RED, random_row());
            write_register(REG_ROW_GREEN, random_row());
            write_register(REG_ROW_BLUE, random_row());
            write_register(REG_MIX, ($urandom_range(3) == 0) ? 48'(13'($urandom())) :
                                                               48'($urandom_range(4096)));
            write_register(REG_KEEP, ($urandom_range(2) == 0) ? 48'd0 :
                                     48'($urandom_range(8191)));
            if (phase == 2) fork long_hold_off(); join_none
            for (int i = 0; i < N_RANDOM / 8; i++) begin
                px = random_pixel();
                send_pixel(px, 1'b0, '0);
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/cmlp_pkg.sv
src/cmlp_matrix.sv
src/cmlp_divider.sv
src/cmlp_scale.sv
src/color_matrix_luma_preserve_unit.sv
tb/color_matrix_luma_preserve_unit_tb.sv
